// File: sv/ordered_value_list_engine_macros.svh
// Assertion macros for the ordered value list engine.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef ORDERED_VALUE_LIST_ENGINE_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_MACROS_SVH

`ifndef SYNTH
`define OVLE_ASSERT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed");
`define OVLE_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");
`else
`define OVLE_ASSERT(label, clk, rst_n, cond, conseq)
`define OVLE_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif

`endif

// File: sv/ovle_pkg.sv
// Shared types and codes for the ordered value list engine.
// No dependencies.
package ovle_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_INS_BEFORE = 3'd1,
        OP_INS_AFTER  = 3'd2,
        OP_DELETE     = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_NOTFOUND = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } state_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_APPEND,
        CMD_INS_BEFORE,
        CMD_INS_AFTER,
        CMD_DELETE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t            cmd;
        logic [VALUE_W-1:0]   key;
        logic [VALUE_W-1:0]   new_value;
        logic [VALUE_W-1:0]   head_value;
    } cell_ctrl_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 found;
        logic                 first;
    } link_t;

endpackage

// File: sv/ovle_in_if.sv
// Input channel of the ordered value list engine: valid/ready plus one operation.
// No dependencies.
interface ovle_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] item_value;
    logic signed [31:0] anchor_value;

    modport source (output valid, output op, output item_value, output anchor_value,
                    input ready);
    modport sink (input valid, input op, input item_value, input anchor_value,
                  output ready);
endinterface

// File: sv/ovle_out_if.sv
// Result channel of the ordered value list engine: valid/ready plus one result.
// No dependencies.
interface ovle_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               last_flag;
    logic [4:0]         entry_count;

    modport source (output valid, output status, output entry_value, output last_flag,
                    output entry_count, input ready);
    modport sink (input valid, input status, input entry_value, input last_flag,
                  input entry_count, output ready);
endinterface

// File: sv/ovle_cell.sv
// One list position: holds a value, compares it with the key, shifts with its neighbors.
// Depends on ovle_pkg.
module ovle_cell #(
    parameter int DEPTH = 16,
    parameter int INDEX = 0
) (
    input  logic                            clk,
    input  ovle_pkg::cell_ctrl_t            ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]      count,
    input  ovle_pkg::link_t                 left,
    input  logic [ovle_pkg::VALUE_W-1:0]    right_value,
    output ovle_pkg::link_t                 link_out
);
    import ovle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               occupied;
    logic               match;
    logic               found_in;

    assign occupied = CW'(INDEX) < count;
    assign match    = occupied && (value_reg == ctrl.key);
    assign found_in = left.found;

    assign link_out.value = value_reg;
    assign link_out.found = found_in | match;
    assign link_out.first = match & ~found_in;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.cmd)
            CMD_APPEND:
            begin
                if (count == CW'(INDEX))
                begin
                    value_next = ctrl.new_value;
                end
            end
            CMD_INS_BEFORE:
            begin
                if (found_in)
                begin
                    value_next = left.value;
                end
                else if (match)
                begin
                    value_next = ctrl.new_value;
                end
            end
            CMD_INS_AFTER:
            begin
                if (left.first)
                begin
                    value_next = ctrl.new_value;
                end
                else if (found_in)
                begin
                    value_next = left.value;
                end
            end
            CMD_DELETE:
            begin
                if (found_in || match)
                begin
                    value_next = right_value;
                end
            end
            CMD_ROTATE:
            begin
                if (count == CW'(INDEX + 1))
                begin
                    value_next = ctrl.head_value;
                end
                else
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: sv/ovle_ctrl.sv
// Sequencer of the ordered value list engine: takes items, drives the cell row, holds results.
// Depends on ovle_pkg, ovle_in_if, ovle_out_if and the assertion macros.
`include "ordered_value_list_engine_macros.svh"

module ovle_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ovle_in_if.sink                         in_ch,
    ovle_out_if.source                      out_ch,
    input  logic [ovle_pkg::VALUE_W-1:0]    head_value,
    input  logic                            found_any,
    output ovle_pkg::cell_ctrl_t            cell_ctrl,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    import ovle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    state_t             state_reg;
    state_t             state_next;
    logic [2:0]         op_reg;
    logic [VALUE_W-1:0] item_reg;
    logic [VALUE_W-1:0] anchor_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      idx_next;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic [CW-1:0]      out_count_reg;

    logic               out_free;
    logic               load;
    status_t            status_new;
    logic [VALUE_W-1:0] value_new;
    logic               last_new;
    logic               list_last;
    logic               is_full;
    logic               is_empty;
    cell_cmd_t          cmd;

    assign out_free  = ~out_valid_reg | out_ch.ready;
    assign is_full   = count_reg == CW'(DEPTH);
    assign is_empty  = count_reg == '0;
    assign list_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign in_ch.ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (op_reg == OP_LIST && !is_empty)
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LIST:
            begin
                if (out_free && list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = CMD_HOLD;
        load       = 1'b0;
        status_new = STATUS_OK;
        value_new  = '0;
        last_new   = 1'b1;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (state_reg == S_EXEC && out_free)
        begin
            idx_next = '0;
            unique case (op_reg)
                OP_APPEND:
                begin
                    load = 1'b1;
                    if (is_full)
                    begin
                        status_new = STATUS_FULL;
                    end
                    else
                    begin
                        cmd        = CMD_APPEND;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_INS_BEFORE, OP_INS_AFTER:
                begin
                    load = 1'b1;
                    priority if (is_empty)
                    begin
                        status_new = STATUS_EMPTY;
                    end
                    else if (!found_any)
                    begin
                        status_new = STATUS_NOTFOUND;
                    end
                    else if (is_full)
                    begin
                        status_new = STATUS_FULL;
                    end
                    else
                    begin
                        cmd        = (op_reg == OP_INS_BEFORE) ? CMD_INS_BEFORE : CMD_INS_AFTER;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DELETE:
                begin
                    load = 1'b1;
                    priority if (is_empty)
                    begin
                        status_new = STATUS_EMPTY;
                    end
                    else if (!found_any)
                    begin
                        status_new = STATUS_NOTFOUND;
                    end
                    else
                    begin
                        cmd        = CMD_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_LIST:
                begin
                    if (is_empty)
                    begin
                        load       = 1'b1;
                        status_new = STATUS_EMPTY;
                    end
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_LIST && out_free)
        begin
            load      = 1'b1;
            value_new = head_value;
            last_new  = list_last;
            cmd       = CMD_ROTATE;
            idx_next  = idx_reg + IW'(1);
        end
    end

    assign cell_ctrl.cmd        = cmd;
    assign cell_ctrl.key        = (op_reg == OP_DELETE) ? item_reg : anchor_reg;
    assign cell_ctrl.new_value  = item_reg;
    assign cell_ctrl.head_value = head_value;
    assign count                = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg     <= in_ch.op;
            item_reg   <= in_ch.item_value;
            anchor_reg <= in_ch.anchor_value;
        end
        if (load)
        begin
            out_status_reg <= status_new;
            out_value_reg  <= value_new;
            out_last_reg   <= last_new;
            out_count_reg  <= count_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.entry_value = out_value_reg;
    assign out_ch.last_flag   = out_last_reg;
    assign out_ch.entry_count = COUNT_OUT_W'(out_count_reg);

    `OVLE_ASSERT(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `OVLE_ASSERT(a_list_nonempty, clk, rst_n, state_reg == S_LIST, count_reg != '0)
    `OVLE_ASSERT_NEXT(a_append_grows, clk, rst_n, (state_reg == S_EXEC) && out_free && (op_reg == OP_APPEND) && !is_full, count_reg == $past(count_reg) + CW'(1))
    `OVLE_ASSERT_NEXT(a_delete_shrinks, clk, rst_n, (state_reg == S_EXEC) && out_free && (op_reg == OP_DELETE) && !is_empty && found_any, count_reg == $past(count_reg) - CW'(1))
    `OVLE_ASSERT(a_list_streams, clk, rst_n, (state_reg == S_LIST) && out_free, load && (cmd == CMD_ROTATE))

endmodule

// File: sv/ordered_value_list_engine.sv
// Top level of the ordered value list engine: a row of value cells under one sequencer.
// Depends on ovle_pkg, ovle_in_if, ovle_out_if, ovle_cell and ovle_ctrl.
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    op, item_value, anchor_value
//  out_ch    out   valid/ready    status, entry_value, last_flag, entry_count
//
// An edit takes the item in S_IDLE; then, in S_EXEC, every cell compares
// its value with the key, the found chain runs along the row and the row shifts.
// For a list, the row rotates one cell per entry, head to tail.
// Reset clears the entry count; cell values are left unknown and never cleared.
// Results sit in an output register; the next item is taken while one waits, and
// the row stalls while the register is full and not taken.
module ordered_value_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ovle_in_if.sink     in_ch,
    ovle_out_if.source  out_ch
);
    import ovle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    link_t      links [DEPTH+1];
    cell_ctrl_t cell_ctrl;
    logic [CW-1:0] count;

    assign links[0] = '0;

    ovle_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .head_value(links[1].value),
        .found_any(links[DEPTH].found),
        .cell_ctrl(cell_ctrl),
        .count(count)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] right_value;

        if (i < DEPTH - 1)
        begin : g_mid
            assign right_value = links[i+2].value;
        end
        else
        begin : g_end
            assign right_value = links[DEPTH].value;
        end

        ovle_cell #(
            .DEPTH(DEPTH),
            .INDEX(i)
        ) u_cell (
            .clk(clk),
            .ctrl(cell_ctrl),
            .count(count),
            .left(links[i]),
            .right_value(right_value),
            .link_out(links[i+1])
        );
    end

endmodule
